// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned CountWidth  = 16;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned SymWidth    = 7;
    localparam int unsigned AccWidth    = 18;
    localparam int unsigned MaxResults  = 4;
    localparam int unsigned AddrWidth   = 3;

    localparam logic [StatusWidth-1:0] STATUS_DATA = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_DONE = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_ERR  = 2'd2;

    localparam logic [CountWidth-1:0] CAPACITY_RESET = 16'hFFFF;

    // register word index of out_capacity
    localparam logic [AddrWidth-3:0] REG_OUT_CAPACITY = 1'b0;

    localparam logic [SymWidth-1:0] SYM_PAD = 7'd64;
    localparam logic [SymWidth-1:0] SYM_BAD = 7'd65;

    typedef struct packed {
        logic [CountWidth-1:0]  byte_total;
        logic [StatusWidth-1:0] status;
        logic [CharWidth-1:0]   out_byte;
    } result_t;

    // map a character to its sextet, or to the pad and invalid codes
    function automatic logic [SymWidth-1:0] sym_value(input logic [CharWidth-1:0] ch);
        logic [SymWidth-1:0] v;
        v = SYM_BAD;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            v = SymWidth'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            v = SymWidth'(ch - 8'h61) + 7'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            v = SymWidth'(ch - 8'h30) + 7'd52;
        end else if (ch == 8'h2B) begin
            v = 7'd62;
        end else if (ch == 8'h2F) begin
            v = 7'd63;
        end else if (ch == 8'h3D) begin
            v = SYM_PAD;
        end
        return v;
    endfunction

endpackage

// ----- sv/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes base64 text one character per transfer into bytes with status.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tdata[7:0] carries one ASCII character, s_tlast marks the
//   final character of a message. Output stream: one result per transfer,
//   m_tdata holds out_byte, status (0 data, 1 done, 2 error) and byte_total;
//   m_tlast marks the final result caused by one input character.
//   An input character is decoded in the cycle it is accepted; its results
//   (zero to four) appear from the next cycle, one per cycle while the
//   receiver is ready, out of a four-entry result buffer. The buffer accepts
//   the next character in the cycle its last pending result is transferred,
//   so characters with at most one result stream at one per cycle while the
//   receiver is ready.
//   The APB port holds out_capacity at address 0; write it only while idle.
//   Reset clears the buffer and decoder state and sets out_capacity to 65535.
//   A transfer with s_tlast clears the decoder state after its results.
//   When the receiver stalls, the buffer holds its results and s_tready stays
//   low while any result is waiting.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_in
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [7:0] out_byte, [9:8] status,
                                            // [25:10] byte_total, [31:26] zero
    output logic                 m_tlast,   // last_of_run
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CountWidth-1:0] capacity_reg;
    logic [1:0]            pos_reg, pos_next;
    logic [AccWidth-1:0]   acc_reg, acc_next;
    logic [CountWidth-1:0] bw_reg, bw_next;
    logic                  stopped_reg, stopped_next;
    result_t               res_reg [MaxResults];
    result_t               res_next [MaxResults];
    logic [2:0]            rem_reg, rem_next;

    logic                  s_xfer, m_xfer, cfg_write;
    logic [SymWidth-1:0]   sym;
    logic                  bad;
    logic [5:0]            sextet;
    logic [AccWidth-1:0]   acc_a;
    logic [23:0]           word;
    logic [1:0]            nb, k;
    logic                  fin, cap_err;
    logic [StatusWidth-1:0] fin_status;
    logic [CharWidth-1:0]  bytes [3];
    logic [CountWidth-1:0] cnt [3];
    result_t               load [MaxResults];
    logic [2:0]            load_count;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[AddrWidth-1:2] == REG_OUT_CAPACITY) ?
                       {16'b0, capacity_reg} : 32'b0;

    assign s_tready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_tready);
    assign s_xfer   = s_tvalid & s_tready;
    assign m_tvalid = (rem_reg != 3'd0);
    assign m_xfer   = m_tvalid & m_tready;
    assign m_tdata  = {6'b0, res_reg[0].byte_total, res_reg[0].status,
                       res_reg[0].out_byte};
    assign m_tlast  = (rem_reg == 3'd1);

    assign sym    = sym_value(s_tdata);
    assign bad    = sym[6];
    assign sextet = sym[5:0];
    assign acc_a  = {acc_reg[11:0], sextet};
    assign word   = {acc_reg, sextet};

    // decode one character against the group position
    always_comb begin
        nb         = 2'd0;
        fin        = 1'b0;
        fin_status = STATUS_DONE;
        bytes[0]   = '0;
        bytes[1]   = '0;
        bytes[2]   = '0;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        unique case (pos_reg)
            2'd0: begin
                if (s_tdata == 8'h00) begin
                    fin = 1'b1;
                end else if (bad || s_tlast) begin
                    fin        = 1'b1;
                    fin_status = STATUS_ERR;
                end else begin
                    acc_next = {12'b0, sextet};
                    pos_next = 2'd1;
                end
            end
            2'd1: begin
                if (bad) begin
                    fin        = 1'b1;
                    fin_status = STATUS_ERR;
                end else if (s_tlast) begin
                    nb       = 2'd1;
                    bytes[0] = acc_a[11:4];
                    fin      = 1'b1;
                end else begin
                    acc_next = acc_a;
                    pos_next = 2'd2;
                end
            end
            2'd2: begin
                if (bad) begin
                    nb       = 2'd1;
                    bytes[0] = acc_reg[11:4];
                    fin      = 1'b1;
                end else if (s_tlast) begin
                    nb       = 2'd2;
                    bytes[0] = acc_a[17:10];
                    bytes[1] = acc_a[9:2];
                    fin      = 1'b1;
                end else begin
                    acc_next = acc_a;
                    pos_next = 2'd3;
                end
            end
            2'd3: begin
                if (bad) begin
                    nb       = 2'd2;
                    bytes[0] = acc_reg[17:10];
                    bytes[1] = acc_reg[9:2];
                    fin      = 1'b1;
                end else begin
                    nb       = 2'd3;
                    bytes[0] = word[23:16];
                    bytes[1] = word[15:8];
                    bytes[2] = word[7:0];
                    fin      = s_tlast;
                    acc_next = '0;
                    pos_next = 2'd0;
                end
            end
            default: begin
                pos_next = pos_reg;
            end
        endcase
    end

    // capacity check on each byte and assembly of the result list
    always_comb begin
        cnt[0] = bw_reg + 16'd1;
        cnt[1] = bw_reg + 16'd2;
        cnt[2] = bw_reg + 16'd3;
        cap_err = 1'b1;
        priority if (nb >= 2'd1 && cnt[0] >= capacity_reg) begin
            k = 2'd1;
        end else if (nb >= 2'd2 && cnt[1] >= capacity_reg) begin
            k = 2'd2;
        end else if (nb == 2'd3 && cnt[2] >= capacity_reg) begin
            k = 2'd3;
        end else begin
            k       = nb;
            cap_err = 1'b0;
        end

        for (int i = 0; i < MaxResults; i++) begin
            load[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < k) begin
                load[i].out_byte   = bytes[i];
                load[i].status     = STATUS_DATA;
                load[i].byte_total = cnt[i];
            end
        end
        if (cap_err || fin) begin
            load[k].out_byte   = '0;
            load[k].status     = cap_err ? STATUS_ERR : fin_status;
            load[k].byte_total = bw_reg + CountWidth'(k);
        end
        load_count = 3'(k) + 3'(cap_err | fin);
        if (stopped_reg) begin
            load_count = 3'd0;
        end

        bw_next      = bw_reg;
        stopped_next = stopped_reg;
        if (!stopped_reg) begin
            bw_next      = bw_reg + CountWidth'(k);
            stopped_next = cap_err | fin;
        end
    end

    // result buffer: load on an input transfer, else shift on an output one
    always_comb begin
        rem_next = rem_reg;
        for (int i = 0; i < MaxResults; i++) begin
            res_next[i] = res_reg[i];
        end
        if (s_xfer) begin
            rem_next = load_count;
            for (int i = 0; i < MaxResults; i++) begin
                res_next[i] = load[i];
            end
        end else if (m_xfer) begin
            rem_next = rem_reg - 3'd1;
            for (int i = 0; i < MaxResults - 1; i++) begin
                res_next[i] = res_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxResults; i++) begin
            res_reg[i] <= res_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            pos_reg      <= 2'd0;
            acc_reg      <= '0;
            bw_reg       <= '0;
            stopped_reg  <= 1'b0;
            rem_reg      <= 3'd0;
        end else begin
            rem_reg <= rem_next;
            if (cfg_write && paddr[AddrWidth-1:2] == REG_OUT_CAPACITY) begin
                capacity_reg <= pwdata[CountWidth-1:0];
            end
            if (s_xfer) begin
                if (s_tlast) begin
                    pos_reg     <= 2'd0;
                    acc_reg     <= '0;
                    bw_reg      <= '0;
                    stopped_reg <= 1'b0;
                end else if (!stopped_reg) begin
                    pos_reg     <= pos_next;
                    acc_reg     <= acc_next;
                    bw_reg      <= bw_next;
                    stopped_reg <= stopped_next;
                end
            end
        end
    end

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 3'(MaxResults))
        else $error("result buffer count out of range");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != STATUS_DATA |-> m_tlast)
        else $error("done or error result not marked last");

    a_eot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tlast |=> pos_reg == 2'd0 && bw_reg == '0 && !stopped_reg)
        else $error("decoder state not cleared after end of text");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && stopped_reg |=> rem_reg == 3'd0)
        else $error("results produced after the message ended");

endmodule
